### rtl/core/mrpd_pkg.sv
// ----------------------------------------------------------------------------
// mrpd_pkg
// Shared types, codes and helpers of the multi-reference p-distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package mrpd_pkg;

    localparam int CNT_W      = 11;
    localparam int NUM_REFS_W = 9;
    localparam int MIN_LEN_W  = 11;
    localparam int CFG_W      = 11;
    localparam int CODE_W     = 3;
    localparam int Q_W        = 16;
    localparam int DIST_W     = 17;
    localparam int DIV_STEPS  = 16;

    localparam logic [CNT_W-1:0]  CNT_MAX  = 11'd2047;
    localparam logic [CODE_W-1:0] CODE_BAD = 3'd4;
    localparam logic [DIST_W-1:0] ONE_Q16  = 17'h10000;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_T = 8'h54;

    // item operation codes
    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // configuration register indexes
    localparam logic REG_NUM_REFS = 1'b0;
    localparam logic REG_MIN_LEN  = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] mis;
        logic [CNT_W-1:0] bad;
    } count_pair_t;

    function automatic logic [CODE_W-1:0] base_code(input logic [7:0] ch);
        logic [CODE_W-1:0] c;
        case (ch)
            CH_A:    c = 3'd0;
            CH_C:    c = 3'd1;
            CH_G:    c = 3'd2;
            CH_T:    c = 3'd3;
            default: c = CODE_BAD;
        endcase
        return c;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

### rtl/core/mrpd_ref_store.sv
// ----------------------------------------------------------------------------
// mrpd_ref_store
// Reference base store: one 3-bit code per (reference, column), one write
// and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpd_ref_store
    import mrpd_pkg::*;
#(
    parameter int ADDR_W = 18
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [CODE_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [CODE_W-1:0] rdata
);

    logic [CODE_W-1:0] mem [2**ADDR_W];
    logic [CODE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/mrpd_count_mem.sv
// ----------------------------------------------------------------------------
// mrpd_count_mem
// Per-reference mismatch and not-usable counters, one write and one
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpd_count_mem
    import mrpd_pkg::*;
#(
    parameter int ADDR_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire count_pair_t       wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output count_pair_t            rdata
);

    count_pair_t mem [2**ADDR_W];
    count_pair_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/mrpd_div.sv
// ----------------------------------------------------------------------------
// mrpd_div
// Restoring divider for the Q0.16 distance: (mis * 2^16 + usable / 2) / usable,
// one quotient bit per cycle. Expects mis < usable, so the quotient fits
// in 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpd_div
    import mrpd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [CNT_W-1:0] mis,
    input  wire logic [CNT_W-1:0] usable,
    output logic                  done,
    output logic      [Q_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [Q_W-1:0]    lo_reg, lo_next;
    logic [Q_W-1:0]    q_reg, q_next;

    logic [CNT_W:0]    trial;
    logic              ge;

    always_comb begin
        trial = {rem_reg, lo_reg[Q_W-1]};
        ge    = trial >= {1'b0, dvs_reg};

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = mis;
            dvs_next  = usable;
            // rounding half-divisor sits in the low dividend bits
            lo_next   = Q_W'(usable >> 1);
            q_next    = '0;
        end else if (busy_reg) begin
            rem_next = ge ? CNT_W'(trial - {1'b0, dvs_reg}) : trial[CNT_W-1:0];
            lo_next  = {lo_reg[Q_W-2:0], 1'b0};
            q_next   = {q_reg[Q_W-2:0], ge};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
    end

    assign done     = busy_reg && (cnt_reg == STEP_W'(DIV_STEPS - 1));
    assign quotient = {q_reg[Q_W-2:0], ge};

endmodule

`default_nettype wire

### rtl/core/multi_reference_pdistance.sv
// ----------------------------------------------------------------------------
// multi_reference_pdistance
// Nucleotide p-distance of one query against many aligned references.
// ----------------------------------------------------------------------------
// One item is handled at a time. A reference store is written as it is taken.
// A start clears the counter memory, one reference a cycle; the same pass runs
// after reset before the first item is taken (configuration writes are taken
// throughout). A query base that is A/C/G/T makes one read-modify-write of the
// counter memory per active reference, pipelined at one reference a cycle in
// ST_SWEEP, then ST_FLUSH; with no active reference, a non-ACGT base or a
// column out of range no sweep runs. A read passes through ST_RDWAIT and
// ST_OUT when the distance is 1.0, and through ST_DIV between them when the
// 16-step divider runs; ST_OUT waits for the result register to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_reference_pdistance
    import mrpd_pkg::*;
#(
    parameter int MAX_REFS = 256,
    parameter int MAX_LEN  = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // op[1:0], ref_index[9:2], position[19:10], base_char[27:20]
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // result_ref[7:0], mismatch_total[18:8], usable_positions[29:19],
    // distance_q16[46:30], query_bad_positions[57:47]
    output logic      [63:0] m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    localparam int RW = $clog2(MAX_REFS);
    localparam int PW = $clog2(MAX_LEN);
    localparam int CW = (RW + 1 > NUM_REFS_W) ? RW + 1 : NUM_REFS_W;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_SWEEP  = 7'b0000100,
        ST_FLUSH  = 7'b0001000,
        ST_RDWAIT = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [RW-1:0]         j_reg, j_next;
    logic [RW-1:0]         clr_idx_reg, clr_idx_next;
    logic                  wr_pend_reg, wr_pend_next;
    logic [RW-1:0]         wr_idx_reg, wr_idx_next;
    logic [PW-1:0]         qpos_reg, qpos_next;
    logic [1:0]            qcode_reg, qcode_next;
    logic [CNT_W-1:0]      qvalid_reg, qvalid_next;
    logic [CNT_W-1:0]      qinvalid_reg, qinvalid_next;
    logic [7:0]            rd_ref_reg, rd_ref_next;
    logic                  rd_ok_reg, rd_ok_next;
    logic [CNT_W-1:0]      res_mis_reg, res_mis_next;
    logic [CNT_W-1:0]      res_use_reg, res_use_next;
    logic [DIST_W-1:0]     res_dist_reg, res_dist_next;
    logic                  m_valid_reg, m_valid_next;
    logic [63:0]           m_tdata_reg, m_tdata_next;
    logic [NUM_REFS_W-1:0] num_refs_reg, num_refs_next;
    logic [MIN_LEN_W-1:0]  min_len_reg, min_len_next;

    logic [1:0]        s_op;
    logic [7:0]        s_ref;
    logic [9:0]        s_pos;
    logic [CODE_W-1:0] s_code;
    logic              s_fire;
    logic              ref_ok;
    logic              pos_ok;
    logic [CW-1:0]     active;
    logic              j_last;

    logic              st_we;
    logic [CODE_W-1:0] st_rdata;
    logic              cm_re;
    logic [RW-1:0]     cm_raddr;
    logic              cm_we;
    logic [RW-1:0]     cm_waddr;
    count_pair_t       cm_wdata;
    count_pair_t       cm_rdata;
    count_pair_t       upd;

    logic              div_start;
    logic              div_done;
    logic [Q_W-1:0]    div_q;
    logic [CNT_W-1:0]  mis_v;
    logic [CNT_W-1:0]  bad_v;
    logic [CNT_W-1:0]  use_v;

    assign s_op   = s_tdata[1:0];
    assign s_ref  = s_tdata[9:2];
    assign s_pos  = s_tdata[19:10];
    assign s_code = base_code(s_tdata[27:20]);
    assign s_fire = s_tvalid && s_tready;
    assign ref_ok = 32'(s_ref) < 32'(MAX_REFS);
    assign pos_ok = 32'(s_pos) < 32'(MAX_LEN);

    assign active = (CW'(num_refs_reg) > CW'(MAX_REFS)) ? CW'(MAX_REFS) : CW'(num_refs_reg);
    assign j_last = (CW'(j_reg) + CW'(1)) == active;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------- memories
    assign st_we = s_fire && (s_op == OP_STORE) && ref_ok && pos_ok;

    mrpd_ref_store #(
        .ADDR_W (RW + PW)
    ) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr ({RW'(s_ref), PW'(s_pos)}),
        .wdata (s_code),
        .re    (state_reg == ST_SWEEP),
        .raddr ({j_reg, qpos_reg}),
        .rdata (st_rdata)
    );

    assign cm_re    = (state_reg == ST_SWEEP) || (s_fire && (s_op == OP_READ));
    assign cm_raddr = (state_reg == ST_SWEEP) ? j_reg : RW'(s_ref);

    always_comb begin
        upd = cm_rdata;
        if (st_rdata[CODE_W-1]) begin
            upd.bad = sat_inc(cm_rdata.bad);
        end else if (st_rdata[1:0] != qcode_reg) begin
            upd.mis = sat_inc(cm_rdata.mis);
        end
    end

    assign cm_we    = (state_reg == ST_CLEAR) || wr_pend_reg;
    assign cm_waddr = (state_reg == ST_CLEAR) ? clr_idx_reg : wr_idx_reg;
    assign cm_wdata = (state_reg == ST_CLEAR) ? count_pair_t'('0) : upd;

    mrpd_count_mem #(
        .ADDR_W (RW)
    ) u_counts (
        .aclk  (aclk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (cm_wdata),
        .re    (cm_re),
        .raddr (cm_raddr),
        .rdata (cm_rdata)
    );

    // ---------------------------------------------------------------- result
    assign mis_v = rd_ok_reg ? cm_rdata.mis : '0;
    assign bad_v = rd_ok_reg ? cm_rdata.bad : '0;
    assign use_v = (qvalid_reg > bad_v) ? qvalid_reg - bad_v : '0;

    mrpd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .mis      (mis_v),
        .usable   (use_v),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------------------------------------------------------- control
    always_comb begin
        state_next    = state_reg;
        j_next        = j_reg;
        clr_idx_next  = clr_idx_reg;
        wr_pend_next  = 1'b0;
        wr_idx_next   = wr_idx_reg;
        qpos_next     = qpos_reg;
        qcode_next    = qcode_reg;
        qvalid_next   = qvalid_reg;
        qinvalid_next = qinvalid_reg;
        rd_ref_next   = rd_ref_reg;
        rd_ok_next    = rd_ok_reg;
        res_mis_next  = res_mis_reg;
        res_use_next  = res_use_reg;
        res_dist_next = res_dist_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        num_refs_next = num_refs_reg;
        min_len_next  = min_len_reg;
        div_start     = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                REG_NUM_REFS: num_refs_next = cfg_wdata[NUM_REFS_W-1:0];
                REG_MIN_LEN:  min_len_next  = cfg_wdata[MIN_LEN_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_idx_next = clr_idx_reg + RW'(1);
                if (clr_idx_reg == RW'(MAX_REFS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_op)
                        OP_STORE: ;
                        OP_START: begin
                            qvalid_next   = '0;
                            qinvalid_next = '0;
                            clr_idx_next  = '0;
                            state_next    = ST_CLEAR;
                        end
                        OP_QUERY: begin
                            if (pos_ok) begin
                                if (s_code == CODE_BAD) begin
                                    qinvalid_next = sat_inc(qinvalid_reg);
                                end else begin
                                    qvalid_next = sat_inc(qvalid_reg);
                                    qpos_next   = PW'(s_pos);
                                    qcode_next  = s_code[1:0];
                                    j_next      = '0;
                                    if (active != '0) begin
                                        state_next = ST_SWEEP;
                                    end
                                end
                            end
                        end
                        OP_READ: begin
                            rd_ref_next = s_ref;
                            rd_ok_next  = ref_ok;
                            state_next  = ST_RDWAIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SWEEP: begin
                // read issued for j_reg now, write-back next cycle
                wr_pend_next = 1'b1;
                wr_idx_next  = j_reg;
                if (j_last) begin
                    state_next = ST_FLUSH;
                end else begin
                    j_next = j_reg + RW'(1);
                end
            end
            ST_FLUSH: begin
                state_next = ST_IDLE;
            end
            ST_RDWAIT: begin
                res_mis_next = mis_v;
                res_use_next = use_v;
                if (use_v == '0 || use_v < min_len_reg || mis_v >= use_v) begin
                    res_dist_next = ONE_Q16;
                    state_next    = ST_OUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    res_dist_next = {1'b0, div_q};
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_tdata_next = {6'b0, qinvalid_reg, res_dist_reg, res_use_reg,
                                    res_mis_reg, rd_ref_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            j_reg        <= '0;
            clr_idx_reg  <= '0;
            wr_pend_reg  <= 1'b0;
            qvalid_reg   <= '0;
            qinvalid_reg <= '0;
            m_valid_reg  <= 1'b0;
            num_refs_reg <= NUM_REFS_W'(256);
            min_len_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            j_reg        <= j_next;
            clr_idx_reg  <= clr_idx_next;
            wr_pend_reg  <= wr_pend_next;
            qvalid_reg   <= qvalid_next;
            qinvalid_reg <= qinvalid_next;
            m_valid_reg  <= m_valid_next;
            num_refs_reg <= num_refs_next;
            min_len_reg  <= min_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_idx_reg   <= wr_idx_next;
        qpos_reg     <= qpos_next;
        qcode_reg    <= qcode_next;
        rd_ref_reg   <= rd_ref_next;
        rd_ok_reg    <= rd_ok_next;
        res_mis_reg  <= res_mis_next;
        res_use_reg  <= res_use_next;
        res_dist_reg <= res_dist_next;
        m_tdata_reg  <= m_tdata_next;
    end

`ifndef SYNTHESIS
    a_no_wb_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_pend_reg |-> (state_reg != ST_CLEAR))
        else $error("counter write-back overlaps clearing pass");

    a_sweep_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (CW'(j_reg) < active))
        else $error("sweep index beyond active references");

    a_div_operands: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (res_mis_reg < res_use_reg))
        else $error("divider running with quotient of 1.0 or more");

    a_store_keeps_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_op == OP_STORE) |=> ($stable(qvalid_reg) && $stable(qinvalid_reg)))
        else $error("reference store changed query counters");
`endif

endmodule

`default_nettype wire
